FILE: hdl/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, register indexes, status codes and the CRC-16 byte update
// for the Modbus RTU response checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam int unsigned ADDR_W = 4;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_SLAVE     = 2'd0;
    localparam logic [1:0] REG_FUNC      = 2'd1;
    localparam logic [1:0] REG_REG_COUNT = 2'd2;

    localparam logic [7:0] RST_SLAVE     = 8'd1;
    localparam logic [6:0] RST_FUNC      = 7'd3;
    localparam logic [6:0] RST_REG_COUNT = 7'd5;

    // Status codes of the final item.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SLAVE     = 3'd1;
    localparam logic [2:0] ST_FUNC      = 3'd2;
    localparam logic [2:0] ST_COUNT     = 3'd3;
    localparam logic [2:0] ST_EXCEPTION = 3'd4;
    localparam logic [2:0] ST_CRC       = 3'd5;

    localparam logic       KIND_WORD   = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    // Function codes that set the data length.
    localparam logic [7:0] FC_READ_HOLD   = 8'd3;
    localparam logic [7:0] FC_READ_INPUT  = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
    localparam logic [7:0] FC_WRITE_REG   = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [8:0]  POS_MAX  = 9'd511;

    typedef struct packed {
        logic [7:0] slave;
        logic [6:0] func;
        logic [6:0] reg_count;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] word;
        logic [2:0]  status;
        logic [7:0]  exc_code;
    } result_t;

    // Reflected CRC-16 over one byte, LSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

FILE: hdl/mrc_apb_regs.sv
// ----------------------------------------------------------------------------
// mrc_apb_regs
// APB-style configuration registers: expected slave, function and count.
// ----------------------------------------------------------------------------
module mrc_apb_regs
    import mrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave     <= RST_SLAVE;
            cfg_reg.func      <= RST_FUNC;
            cfg_reg.reg_count <= RST_REG_COUNT;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SLAVE:     cfg_reg.slave     <= pwdata[7:0];
                REG_FUNC:      cfg_reg.func      <= pwdata[6:0];
                REG_REG_COUNT: cfg_reg.reg_count <= pwdata[6:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SLAVE:     prdata = {24'd0, cfg_reg.slave};
            REG_FUNC:      prdata = {25'd0, cfg_reg.func};
            REG_REG_COUNT: prdata = {25'd0, cfg_reg.reg_count};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

FILE: hdl/mrc_frame_check.sv
// ----------------------------------------------------------------------------
// mrc_frame_check
// Per-frame state and the single-pass byte step: header capture, CRC update,
// word assembly and the prioritized status decision on the last byte.
// ----------------------------------------------------------------------------
module mrc_frame_check
    import mrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  logic       end_of_frame,
    input  cfg_t       cfg,
    output logic       res_valid,
    output result_t    res
);

    logic [8:0]  pos_reg,       pos_next;
    logic [15:0] crc_reg,       crc_next;
    logic [7:0]  slave_reg,     slave_next;
    logic [7:0]  func_reg,      func_next;
    logic [7:0]  count_reg,     count_next;
    logic [7:0]  high_reg,      high_next;
    logic [7:0]  crc_lo_reg,    crc_lo_next;
    logic [7:0]  crc_hi_reg,    crc_hi_next;

    // Values after this byte has been folded in.
    logic [7:0]  slave_cur, func_cur, count_cur;
    logic [7:0]  crc_lo_cur, crc_hi_cur, high_cur;
    logic [15:0] crc_cur;
    logic [8:0]  len;
    logic [9:0]  pos_w, n_w, data_end, frame_need;
    logic        in_data, is_reads, word_ready;
    logic [2:0]  st;

    assign pos_w = {1'b0, pos_reg};
    assign n_w   = pos_w + 10'd1;

    always_comb
    begin
        slave_cur = (pos_reg == 9'd0) ? rx_byte : slave_reg;
        func_cur  = (pos_reg == 9'd1) ? rx_byte : func_reg;
        count_cur = (pos_reg == 9'd2) ? rx_byte : count_reg;

        case (func_cur)
            FC_READ_HOLD, FC_READ_INPUT:  len = {1'b0, count_cur};
            FC_WRITE_COIL, FC_WRITE_REG,
            FC_WRITE_COILS, FC_WRITE_REGS: len = 9'd3;
            default:                       len = 9'd0;
        endcase

        data_end   = 10'd3 + {1'b0, len};
        frame_need = data_end + 10'd2;
        in_data    = pos_w < data_end;
        is_reads   = (func_cur == FC_READ_HOLD) || (func_cur == FC_READ_INPUT);

        crc_cur = in_data ? crc16_byte(crc_reg, rx_byte) : crc_reg;

        // Data bytes start at position 3, so an odd position is a high byte.
        high_cur   = high_reg;
        word_ready = 1'b0;
        if ((pos_reg >= 9'd3) && in_data && is_reads)
        begin
            if (pos_reg[0])
                high_cur = rx_byte;
            else
                word_ready = 1'b1;
        end

        crc_lo_cur = (pos_w == data_end) ? rx_byte : crc_lo_reg;
        crc_hi_cur = (pos_w == data_end + 10'd1) ? rx_byte : crc_hi_reg;

        if (slave_cur != cfg.slave)
            st = ST_SLAVE;
        else if (n_w < 10'd2)
            st = ST_CRC;
        else if (func_cur[6:0] != cfg.func)
            st = ST_FUNC;
        else if (n_w < 10'd3)
            st = ST_CRC;
        else if ((func_cur == FC_READ_HOLD) && (cfg.reg_count != count_cur[7:1]))
            st = ST_COUNT;
        else if (func_cur[7])
            st = ST_EXCEPTION;
        else if (n_w < frame_need)
            st = ST_CRC;
        else if ({crc_hi_cur, crc_lo_cur} != crc_cur)
            st = ST_CRC;
        else
            st = ST_OK;

        res_valid = accept & (end_of_frame | word_ready);
        if (end_of_frame)
        begin
            res.kind     = KIND_STATUS;
            res.word     = 16'd0;
            res.status   = st;
            res.exc_code = (st == ST_EXCEPTION) ? count_cur : 8'd0;
        end
        else
        begin
            res.kind     = KIND_WORD;
            res.word     = {high_reg, rx_byte};
            res.status   = ST_OK;
            res.exc_code = 8'd0;
        end

        pos_next    = pos_reg;
        crc_next    = crc_reg;
        slave_next  = slave_reg;
        func_next   = func_reg;
        count_next  = count_reg;
        high_next   = high_reg;
        crc_lo_next = crc_lo_reg;
        crc_hi_next = crc_hi_reg;
        if (accept)
        begin
            if (end_of_frame)
            begin
                pos_next    = 9'd0;
                crc_next    = CRC_SEED;
                slave_next  = 8'd0;
                func_next   = 8'd0;
                count_next  = 8'd0;
                high_next   = 8'd0;
                crc_lo_next = 8'd0;
                crc_hi_next = 8'd0;
            end
            else
            begin
                pos_next    = (pos_reg == POS_MAX) ? POS_MAX : n_w[8:0];
                crc_next    = crc_cur;
                slave_next  = slave_cur;
                func_next   = func_cur;
                count_next  = count_cur;
                high_next   = high_cur;
                crc_lo_next = crc_lo_cur;
                crc_hi_next = crc_hi_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 9'd0;
            crc_reg    <= CRC_SEED;
            slave_reg  <= 8'd0;
            func_reg   <= 8'd0;
            count_reg  <= 8'd0;
            high_reg   <= 8'd0;
            crc_lo_reg <= 8'd0;
            crc_hi_reg <= 8'd0;
        end
        else
        begin
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            slave_reg  <= slave_next;
            func_reg   <= func_next;
            count_reg  <= count_next;
            high_reg   <= high_next;
            crc_lo_reg <= crc_lo_next;
            crc_hi_reg <= crc_hi_next;
        end
    end

endmodule

FILE: hdl/mrc_out_reg.sv
// ----------------------------------------------------------------------------
// mrc_out_reg
// Result register on the output channel. It holds a beat while the consumer
// stalls and reloads in the same cycle that the held beat is taken.
// ----------------------------------------------------------------------------
module mrc_out_reg
    import mrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    input  logic    out_stall,
    output logic    out_valid,
    output logic    full_blocked,
    output result_t out_data
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign full_blocked = valid_reg & out_stall;
    assign out_valid    = valid_reg;
    assign out_data     = data_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

endmodule

FILE: hdl/modbus_response_checker.sv
// ----------------------------------------------------------------------------
// Result beats: a beat is on the output in the cycle after its byte is taken.
// Throughput: one byte per cycle while in_stall is low; the CRC update and checks are combinational.
// Input stalls only while a held result beat is itself stalled.
// Reset: rst_n clears the frame state and the result valid flag at once and
// restores expected slave 1, function 3 and register count 5.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// modbus_response_checker
// Checks a Modbus RTU response byte stream against the configured request,
// emits register words for read functions and a status beat per frame.
// ----------------------------------------------------------------------------
module modbus_response_checker
    import mrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    input  logic              end_of_frame,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              item_kind,
    output logic [15:0]       data_word,
    output logic [2:0]        status,
    output logic [7:0]        exception_code
);

    cfg_t    cfg;
    result_t res;
    result_t out_data;
    logic    res_valid;
    logic    accept;
    logic    blocked;

    assign in_stall = blocked;
    assign accept   = in_valid & ~blocked;

    mrc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mrc_frame_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .rx_byte      (rx_byte),
        .end_of_frame (end_of_frame),
        .cfg          (cfg),
        .res_valid    (res_valid),
        .res          (res)
    );

    mrc_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (res_valid),
        .load_data    (res),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .full_blocked (blocked),
        .out_data     (out_data)
    );

    assign item_kind      = out_data.kind;
    assign data_word      = out_data.word;
    assign status         = out_data.status;
    assign exception_code = out_data.exc_code;

endmodule
